### hw/rtl/atomic_memory_op_unit_assert.svh
// Assertion macros shared by the atomic memory operation unit.
`ifndef ATOMIC_MEMORY_OP_UNIT_ASSERT_SVH
`define ATOMIC_MEMORY_OP_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define AMOU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("amou assertion failed");

// Next-cycle implication, checked outside reset.
`define AMOU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("amou assertion failed");

`endif

### hw/rtl/amou_pkg.sv
// Package: types and constants of the atomic memory operation unit.
package amou_pkg;

  localparam int AMOU_MEM_WORDS = 1024;

  localparam int DATA_W      = 64;
  localparam int HALF_W      = 32;
  localparam int IDX_W       = 11;
  localparam int SLOT_W      = 10;
  localparam int LIMIT_W     = 12;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 72;

  localparam logic [LIMIT_W-1:0] MAPPED_LIMIT_RST   = 12'd2048;
  localparam logic [LIMIT_W-1:0] READONLY_LIMIT_RST = 12'd0;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COMPARE  = 2'd0,
    CFG_MAPPED   = 2'd1,
    CFG_READONLY = 2'd2
  } cfg_idx_t;

  // Atomic operation codes
  typedef enum logic [CMD_W-1:0] {
    CMD_EXCH    = 3'd0,
    CMD_CMPEXCH = 3'd1,
    CMD_FADD    = 3'd2,
    CMD_FADDGEZ = 3'd3,
    CMD_FAND    = 3'd4,
    CMD_FOR     = 3'd5
  } cmd_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_UNMAPPED = 2'd1,
    ST_ACCESS   = 2'd2
  } status_t;

endpackage

### hw/rtl/atomic_memory_op_unit.sv
// Atomic read-modify-write unit: top level with word memory and forwarding.
// A request is held in the compute stage, then its result in the output register.
// Throughput: one request per cycle while out_tready keeps up; the memory has one read
// and one write port; the last write is forwarded to the request read in the same cycle.
// Reset: synchronous, active low; then a clearing pass writes zeros to all
// MEM_WORDS memory words, one per cycle, with in_tready low until it ends.
`include "atomic_memory_op_unit_assert.svh"

module atomic_memory_op_unit
  import amou_pkg::*;
#(
  parameter int MEM_WORDS = AMOU_MEM_WORDS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Request stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // cmd[2:0], quad[3], word_index[14:4], operand[78:15]
  // Result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // old_value[63:0], wrote[64], status[66:65]
  // Configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DATA_W-1:0]      cfg_data
);

  localparam int AW = $clog2(MEM_WORDS);

  // Configuration registers
  logic [DATA_W-1:0]  cmp_r;
  logic [LIMIT_W-1:0] map_lim_r;
  logic [LIMIT_W-1:0] ro_lim_r;

  // Clearing pass
  logic          clr_busy_r, clr_busy_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  // Compute stage
  logic              s1_valid_r, s1_valid_nxt;
  cmd_t              s1_cmd_r;
  logic              s1_quad_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic [DATA_W-1:0] s1_opnd_r;
  logic [DATA_W-1:0] rd_data_r;

  // Last write, forwarded to the following read
  logic              fwd_vld_r;
  logic [AW-1:0]     fwd_addr_r;
  logic [DATA_W-1:0] fwd_data_r;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_old_r;
  logic              out_wrote_r;
  status_t           out_status_r;

  // Memory
  logic [DATA_W-1:0] mem [MEM_WORDS];
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [DATA_W-1:0] mem_wd;

  logic              in_fire, s1_adv, s1_fire;
  logic [AW-1:0]     in_addr, s1_addr;

  // Compute results
  logic [DATA_W-1:0] old64, oldv, cmpv, sum, newv, merged;
  logic [HALF_W-1:0] half;
  logic              do_write, cmd_ok, unmapped, ro_hit, rmw_we;
  logic [IDX_W-1:0]  lo_idx, hi_idx;
  logic [DATA_W-1:0] res_old;
  logic              res_wrote;
  status_t           res_status;

  // Handshakes
  assign s1_adv    = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s1_adv;
  assign in_tready = !clr_busy_r && (!s1_valid_r || s1_adv);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign in_addr = AW'(in_tdata[14:5]);
  assign s1_addr = AW'(s1_idx_r[IDX_W-1:1]);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_r     <= '0;
      map_lim_r <= MAPPED_LIMIT_RST;
      ro_lim_r  <= READONLY_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_COMPARE:  cmp_r     <= cfg_data;
        CFG_MAPPED:   map_lim_r <= cfg_data[LIMIT_W-1:0];
        CFG_READONLY: ro_lim_r  <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-modify-write datapath
  always_comb begin
    old64  = (fwd_vld_r && (fwd_addr_r == s1_addr)) ? fwd_data_r : rd_data_r;
    half   = s1_idx_r[0] ? old64[DATA_W-1:HALF_W] : old64[HALF_W-1:0];
    oldv   = s1_quad_r ? old64 : {{HALF_W{half[HALF_W-1]}}, half};
    cmpv   = s1_quad_r ? cmp_r : {{HALF_W{cmp_r[HALF_W-1]}}, cmp_r[HALF_W-1:0]};
    sum    = s1_opnd_r + oldv;
    newv   = s1_opnd_r;
    do_write = 1'b1;
    cmd_ok   = 1'b1;
    unique case (s1_cmd_r)
      CMD_EXCH:    newv = s1_opnd_r;
      CMD_CMPEXCH: do_write = (oldv == cmpv);
      CMD_FADD:    newv = sum;
      CMD_FADDGEZ: begin
        newv     = sum;
        do_write = s1_quad_r ? !sum[DATA_W-1] : !sum[HALF_W-1];
      end
      CMD_FAND:    newv = s1_opnd_r & oldv;
      CMD_FOR:     newv = s1_opnd_r | oldv;
      default: begin
        cmd_ok   = 1'b0;
        do_write = 1'b0;
      end
    endcase

    // Address checks on both 32-bit halves touched
    lo_idx   = s1_quad_r ? {s1_idx_r[IDX_W-1:1], 1'b0} : s1_idx_r;
    hi_idx   = s1_quad_r ? {s1_idx_r[IDX_W-1:1], 1'b1} : s1_idx_r;
    unmapped = ({1'b0, hi_idx} >= map_lim_r) ||
               (32'(s1_idx_r[IDX_W-1:1]) >= 32'(MEM_WORDS));
    ro_hit   = ({1'b0, lo_idx} < ro_lim_r);

    // Word written back: the whole result for quad, else the 32-bit result merged into its half
    if (s1_quad_r) begin
      merged = newv;
    end else if (s1_idx_r[0]) begin
      merged = {newv[HALF_W-1:0], old64[HALF_W-1:0]};
    end else begin
      merged = {old64[DATA_W-1:HALF_W], newv[HALF_W-1:0]};
    end

    res_old    = '0;
    res_wrote  = 1'b0;
    res_status = ST_OK;
    rmw_we     = 1'b0;
    if (!cmd_ok) begin
      res_status = ST_OK;
    end else if (unmapped) begin
      res_status = ST_UNMAPPED;
    end else if (do_write && ro_hit) begin
      res_status = ST_ACCESS;
    end else begin
      res_old   = oldv;
      res_wrote = do_write;
      rmw_we    = do_write;
    end
  end

  // Memory write port: clearing pass, then updates
  assign mem_we = clr_busy_r || (s1_fire && rmw_we);
  assign mem_wa = clr_busy_r ? clr_addr_r : s1_addr;
  assign mem_wd = clr_busy_r ? '0 : merged;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (in_fire) begin
      rd_data_r <= mem[in_addr];
    end
  end

  // Control next state
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(MEM_WORDS - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end

    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_vld_r   <= 1'b0;
    end else begin
      clr_busy_r  <= clr_busy_nxt;
      clr_addr_r  <= clr_addr_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire && rmw_we) begin
        fwd_vld_r <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= cmd_t'(in_tdata[2:0]);
      s1_quad_r <= in_tdata[3];
      s1_idx_r  <= in_tdata[14:4];
      s1_opnd_r <= in_tdata[78:15];
    end
    if (s1_fire) begin
      out_old_r    <= res_old;
      out_wrote_r  <= res_wrote;
      out_status_r <= res_status;
    end
    if (s1_fire && rmw_we) begin
      fwd_addr_r <= s1_addr;
      fwd_data_r <= merged;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_status_r, out_wrote_r, out_old_r};

  // Checks
  `AMOU_ASSERT_IMP(a_fault_clean, clk, rst_n,
    out_valid_r && (out_status_r != ST_OK), !out_wrote_r && (out_old_r == '0))
  `AMOU_ASSERT_IMP(a_clear_idle, clk, rst_n,
    clr_busy_r, !s1_valid_r && !out_valid_r && !fwd_vld_r)
  `AMOU_ASSERT_NXT(a_write_result, clk, rst_n,
    s1_fire && rmw_we, out_valid_r && out_wrote_r && (out_status_r == ST_OK))

endmodule

### dv/tb_atomic_memory_op_unit.sv
`timescale 1ns / 1ps
// Testbench for the atomic read-modify-write unit: directed and random requests vs. a predictor.
module tb_atomic_memory_op_unit;
  import amou_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 3'd7;
  localparam int MAX_IDLE      = 18;
  localparam int STALL_LIMIT   = 5000;  // covers the clearing pass after reset
  localparam int DRAIN_CYCLES  = 4;
  localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
  localparam logic [DATA_W-1:0] MIN_S64  = 64'h8000_0000_0000_0000;
  localparam logic [DATA_W-1:0] MAX_S64  = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [DATA_W-1:0]   old_value;
    logic                wrote;
    logic [STATUS_W-1:0] status;
  } amo_result_t;

  // Memory image, register copy and the queue of results still owed by the block
  class amo_scoreboard;
    logic [DATA_W-1:0]  mem_image [AMOU_MEM_WORDS];
    logic [DATA_W-1:0]  compare_reg;
    logic [LIMIT_W-1:0] mapped_reg;
    logic [LIMIT_W-1:0] readonly_reg;
    amo_result_t        owed_results [$];
    int                 errors;

    function new();
      foreach (mem_image[i]) mem_image[i] = '0;
      compare_reg  = '0;
      mapped_reg   = MAPPED_LIMIT_RST;
      readonly_reg = READONLY_LIMIT_RST;
      errors       = 0;
    endfunction

    function logic [DATA_W-1:0] sext_word(logic [HALF_W-1:0] v);
      return {{HALF_W{v[HALF_W-1]}}, v};
    endfunction

    function void set_reg(cfg_idx_t idx, logic [DATA_W-1:0] value);
      case (idx)
        CFG_COMPARE:  compare_reg  = value;
        CFG_MAPPED:   mapped_reg   = value[LIMIT_W-1:0];
        CFG_READONLY: readonly_reg = value[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // Apply one accepted request to the memory image and queue its result
    function void note_request(logic [CMD_W-1:0] cmd, logic quad, logic [IDX_W-1:0] idx,
                               logic [DATA_W-1:0] opnd);
      amo_result_t       res;
      logic [IDX_W-1:0]  lo_idx, hi_idx;
      logic [SLOT_W-1:0] slot;
      logic [DATA_W-1:0] oldv, newv, cmpv;
      logic              do_write;
      res.old_value = '0;
      res.wrote     = 1'b0;
      res.status    = ST_OK;
      lo_idx = quad ? {idx[IDX_W-1:1], 1'b0} : idx;
      hi_idx = quad ? {idx[IDX_W-1:1], 1'b1} : idx;
      slot   = idx[IDX_W-1:1];
      if (cmd > CMD_FOR) begin
        // undefined command: no effect, plain zero result
      end else if ({1'b0, hi_idx} >= mapped_reg) begin
        res.status = ST_UNMAPPED;
      end else begin
        if (quad)
          oldv = mem_image[slot];
        else
          oldv = sext_word(idx[0] ? mem_image[slot][63:32] : mem_image[slot][31:0]);
        do_write = 1'b1;
        case (cmd)
          CMD_EXCH: newv = opnd;
          CMD_CMPEXCH: begin
            cmpv     = quad ? compare_reg : sext_word(compare_reg[HALF_W-1:0]);
            newv     = opnd;
            do_write = (oldv == cmpv);
          end
          CMD_FADD: newv = opnd + oldv;
          CMD_FADDGEZ: begin
            newv     = opnd + oldv;
            do_write = quad ? !newv[63] : !newv[31];
          end
          CMD_FAND: newv = opnd & oldv;
          default:  newv = opnd | oldv;
        endcase
        if (do_write && ({1'b0, lo_idx} < readonly_reg)) begin
          res.status = ST_ACCESS;
        end else begin
          if (do_write) begin
            if (quad)
              mem_image[slot] = newv;
            else if (idx[0])
              mem_image[slot][63:32] = newv[31:0];
            else
              mem_image[slot][31:0] = newv[31:0];
          end
          res.old_value = oldv;
          res.wrote     = do_write;
        end
      end
      owed_results.push_back(res);
    endfunction

    // Compare one result transfer with the oldest owed result
    function void check_result(logic [OUT_TDATA_W-1:0] tdata);
      amo_result_t want;
      if (owed_results.size() == 0) begin
        $error("result transfer with none owed: old_value %h", tdata[63:0]);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      if (tdata[63:0] !== want.old_value) begin
        $error("old_value: expected %h, actual %h", want.old_value, tdata[63:0]);
        errors++;
      end
      if (tdata[64] !== want.wrote) begin
        $error("wrote: expected %0d, actual %0d", want.wrote, tdata[64]);
        errors++;
      end
      if (tdata[66:65] !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, tdata[66:65]);
        errors++;
      end
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // cmd, quad, word_index, operand, pad
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // old_value, wrote, status, pad
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  cfg_idx_t               cfg_index  = CFG_COMPARE;
  logic [DATA_W-1:0]      cfg_data   = '0;

  amo_scoreboard     sb;
  bit                send_fast;
  bit                sink_fast;
  logic [DATA_W-1:0] cur_compare;
  int                quiet_cycles;

  always #5 clk = ~clk;

  atomic_memory_op_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata);
  end

  // Result sink: random stall before each transfer, none in fast stretches
  initial begin : result_sink
    int stall;
    @(posedge clk);
    forever begin
      stall = sink_fast ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("atomic_memory_op_unit verification failed");
      $finish;
    end
  end

  // Write all three registers back to back; valid drops only after the last transfer
  task automatic set_config(logic [DATA_W-1:0] compare, int mapped, int readonly);
    logic [DATA_W-1:0] vals [3];
    cfg_idx_t          regs [3];
    vals[0] = compare;
    vals[1] = DATA_W'(mapped);
    vals[2] = DATA_W'(readonly);
    regs[0] = CFG_COMPARE;
    regs[1] = CFG_MAPPED;
    regs[2] = CFG_READONLY;
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(regs[i], vals[i]);
    end
    cfg_valid   <= 1'b0;
    cur_compare  = compare;
  endtask

  // One request transfer after a random gap, none in fast stretches
  task automatic send_request(logic [CMD_W-1:0] cmd, logic quad, logic [IDX_W-1:0] idx,
                              logic [DATA_W-1:0] opnd);
    int gap;
    gap = send_fast ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, opnd, idx, quad, cmd};
    do @(posedge clk); while (!in_tready);
    sb.note_request(cmd, quad, idx, opnd);
  endtask

  // Stop sending and wait until every owed result has arrived
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
  endtask

  // Operands biased toward boundary values and the current compare value
  function automatic logic [DATA_W-1:0] pick_value();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 5))
      0, 1: return {$urandom, $urandom};
      2:    return DATA_W'($signed($urandom_range(0, 31)) - 16);
      3:    return {{HALF_W{r[31]}}, r};
      4: begin
        case ($urandom_range(0, 7))
          0: return '0;
          1: return ALL_ONES;
          2: return MIN_S64;
          3: return MAX_S64;
          4: return 64'h0000_0000_8000_0000;
          5: return 64'hFFFF_FFFF_7FFF_FFFF;
          6: return 64'h0000_0000_0000_0001;
          default: return 64'hFFFF_FFFF_0000_0000;
        endcase
      end
      default: return cur_compare;
    endcase
  endfunction

  // Indices mostly at both ends of the word space, so addresses repeat
  function automatic logic [IDX_W-1:0] pick_index();
    case ($urandom_range(0, 4))
      0, 1: return IDX_W'($urandom_range(0, 23));
      2:    return IDX_W'($urandom_range(2032, 2047));
      default: return IDX_W'($urandom_range(0, 2047));
    endcase
  endfunction

  function automatic int pick_limit(bit low_end);
    case ($urandom_range(0, 2))
      0:       return low_end ? 0 : 2048;
      1:       return $urandom_range(0, 24);
      default: return $urandom_range(2032, 2048);
    endcase
  endfunction

  // Random requests, then a full drain so registers can change afterwards
  task automatic run_phase(int count);
    int               r;
    logic [CMD_W-1:0] cmd;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        send_fast = ($urandom_range(0, 3) == 0);
        sink_fast = ($urandom_range(0, 3) == 0);
      end
      r   = $urandom_range(0, 19);
      cmd = (r < 18) ? CMD_W'(r % 6) : ((r == 18) ? CMD_UNDEF_LO : CMD_UNDEF_HI);
      send_request(cmd, 1'($urandom_range(0, 1)), pick_index(), pick_value());
    end
    drain();
  endtask

  initial begin
    sb          = new();
    cur_compare = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every operation, all but FADD and FOR at both widths, sign and wrap corners
    set_config('0, 2048, 0);
    send_request(CMD_EXCH,    1'b1, 11'd0,    64'h8000_0000_0000_0001);
    send_request(CMD_EXCH,    1'b0, 11'd3,    64'hFFFF_FFFF_8000_0000);
    send_request(CMD_FADD,    1'b0, 11'd3,    64'h0000_0000_0000_0001);
    send_request(CMD_CMPEXCH, 1'b1, 11'd2,    ALL_ONES);            // no match
    send_request(CMD_CMPEXCH, 1'b0, 11'd2,    64'h0000_0000_0000_1234);
    send_request(CMD_FADDGEZ, 1'b1, 11'd0,    '0);                  // negative sum
    send_request(CMD_FADDGEZ, 1'b1, 11'd0,    MAX_S64);             // wraps to zero
    send_request(CMD_FADDGEZ, 1'b0, 11'd4,    64'h0000_0000_FFFF_FFFF);
    send_request(CMD_FADDGEZ, 1'b0, 11'd4,    64'h0000_0000_7FFF_FFFF);
    send_request(CMD_FAND,    1'b1, 11'd2047, ALL_ONES);
    send_request(CMD_FOR,     1'b0, 11'd2047, ALL_ONES);
    send_request(CMD_FAND,    1'b0, 11'd2046, '0);
    send_request(CMD_UNDEF_LO, 1'b1, 11'd5,   ALL_ONES);
    send_request(CMD_UNDEF_HI, 1'b0, 11'd6,   MIN_S64);
    send_request(CMD_EXCH,    1'b1, 11'd1,    MIN_S64);             // odd index, quad
    drain();

    // Directed: mapped and read-only boundaries
    set_config(ALL_ONES, 10, 4);
    send_request(CMD_EXCH,    1'b1, 11'd9,    MAX_S64);
    send_request(CMD_FADD,    1'b1, 11'd10,   64'h0000_0000_0000_0001);
    send_request(CMD_FOR,     1'b0, 11'd9,    64'h0000_0000_0000_00F0);
    send_request(CMD_EXCH,    1'b0, 11'd10,   ALL_ONES);
    send_request(CMD_UNDEF_HI, 1'b0, 11'd2000, ALL_ONES);           // undefined beats unmapped
    send_request(CMD_EXCH,    1'b0, 11'd3,    ALL_ONES);            // read-only
    send_request(CMD_CMPEXCH, 1'b0, 11'd2,    ALL_ONES);            // fails, so no fault
    send_request(CMD_EXCH,    1'b1, 11'd3,    ALL_ONES);            // low half read-only
    send_request(CMD_FADDGEZ, 1'b1, 11'd5,    64'h0000_0000_0000_0002);
    drain();

    // Random phases, the first ones at register extremes
    set_config(MIN_S64, 2048, 0);
    run_phase(300);
    set_config(MAX_S64, 0, 2048);
    run_phase(60);
    set_config('0, 2048, 2048);
    run_phase(200);
    set_config(ALL_ONES, 1, 1);
    run_phase(150);
    for (int p = 0; p < 6; p++) begin
      set_config(pick_value(), pick_limit(1'b0), pick_limit(1'b1));
      run_phase(170);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("atomic_memory_op_unit verification clean");
    else
      $display("atomic_memory_op_unit verification failed");
    $finish;
  end

endmodule
